@@ src/spwm_pkg.sv @@
`timescale 1ns / 1ps

package spwm_pkg;

  // Table and datapath sizes
  localparam int TABLE_DEPTH = 256;
  localparam int DUTY_W      = 16;
  localparam int CARR_W      = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PERIOD_W    = 16;
  localparam int SAMPLE_W    = 32;
  localparam int START_W     = 8;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int PHASES      = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_A_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_B_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_C_START = 3'd4;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 16'd4999;
  localparam logic [SAMPLE_W-1:0] SAMPLE_PERIOD_RST = 32'd99999;
  localparam logic [START_W-1:0]  PHASE_A_START_RST = 8'd0;
  localparam logic [START_W-1:0]  PHASE_B_START_RST = 8'd85;
  localparam logic [START_W-1:0]  PHASE_C_START_RST = 8'd170;

  // Fixed-point constants for the table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic [PERIOD_W-1:0] pwm_period;
    logic [SAMPLE_W-1:0] sample_period;
    logic [START_W-1:0]  phase_a_start;
    logic [START_W-1:0]  phase_b_start;
    logic [START_W-1:0]  phase_c_start;
  } cfg_t;

  typedef logic [PHASES-1:0][CARR_W-1:0] cmp_vec_t;
  typedef logic [PHASES-1:0][IDX_W-1:0]  idx_vec_t;

  // Sine table entry: 0.5 + 0.5*sin(2*pi*i/TABLE_DEPTH) in DUTY_W fraction bits.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [DUTY_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] e;
    logic [1:0]  q;
    p = (64'(i) << 32) / TABLE_DEPTH;
    q = p[31:30];
    r = {34'd0, p[29:0]};
    if (q[0]) r = ONE_Q30 - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    // Taylor series, seven terms with alternating sign
    t = ((t * x2) >> 30) / 64'd6;
    s = (s >= t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd20;
    s = s + t;
    t = ((t * x2) >> 30) / 64'd42;
    s = (s >= t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd72;
    s = s + t;
    t = ((t * x2) >> 30) / 64'd110;
    s = (s >= t) ? s - t : 64'd0;
    t = ((t * x2) >> 30) / 64'd156;
    s = s + t;
    if (s > ONE_Q30) s = ONE_Q30;
    if (q < 2'd2) d = (ONE_Q30 >> 1) + (s >> 1);
    else d = (ONE_Q30 >> 1) - (s >> 1);
    e = (d + (64'd1 << (29 - DUTY_W))) >> (30 - DUTY_W);
    if (e > ((64'd1 << DUTY_W) - 64'd1)) e = (64'd1 << DUTY_W) - 64'd1;
    return DUTY_W'(e);
  endfunction

  // Step an index through the table, wrapping after the last entry
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    res = ({1'b0, idx} < (IDX_W+1)'(TABLE_DEPTH - 1)) ? idx + 1'b1 : '0;
    return res;
  endfunction

  // Start register folded into the table range
  function automatic logic [IDX_W-1:0] start_index(input logic [START_W-1:0] start);
    logic [IDX_W-1:0] res;
    res = IDX_W'(start % TABLE_DEPTH);
    return res;
  endfunction

endpackage

@@ src/spwm_duty.sv @@
`timescale 1ns / 1ps

module spwm_duty import spwm_pkg::*; (
  input  logic [IDX_W-1:0]  idx,
  input  logic [CARR_W-1:0] top,
  output logic [CARR_W-1:0] cmp
);

  localparam int PROD_W = DUTY_W + CARR_W + 1;

  logic [DUTY_W-1:0] rom [TABLE_DEPTH];
  logic [DUTY_W-1:0] entry;
  logic [CARR_W:0]   top_p1;
  logic [PROD_W-1:0] prod;

  // Constant sine table
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [DUTY_W-1:0] ENTRY = sine_entry(g);
    assign rom[g] = ENTRY;
  end

  // Scale the duty fraction to the carrier period
  assign entry  = rom[idx];
  assign top_p1 = (CARR_W+1)'(top) + 1'b1;
  assign prod   = PROD_W'(entry) * PROD_W'(top_p1);
  assign cmp    = prod[DUTY_W +: CARR_W];

endmodule

@@ src/spwm_seq.sv @@
`timescale 1ns / 1ps

module spwm_seq import spwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     restart,
  input  cfg_t     cfg,
  output logic     fired,
  output cmp_vec_t shadow_nxt
);

  logic [SAMPLE_W-1:0] count_r;
  logic [SAMPLE_W-1:0] count_nxt;
  idx_vec_t            idx_r;
  idx_vec_t            idx_nxt;
  idx_vec_t            idx_step;
  idx_vec_t            idx_start;
  cmp_vec_t            shadow_r;
  cmp_vec_t            cmp_new;

  assign idx_start[0] = start_index(cfg.phase_a_start);
  assign idx_start[1] = start_index(cfg.phase_b_start);
  assign idx_start[2] = start_index(cfg.phase_c_start);

  // Sample timer
  assign fired     = !restart && (count_r >= cfg.sample_period);
  assign count_nxt = (restart || fired) ? '0 : count_r + 1'b1;

  // Advance indices and form new compares
  for (genvar p = 0; p < PHASES; p++) begin : g_phase
    assign idx_step[p] = next_index(idx_r[p]);
    assign idx_nxt[p]  = restart ? idx_start[p] : (fired ? idx_step[p] : idx_r[p]);

    spwm_duty u_duty (
      .idx (idx_step[p]),
      .top (cfg.pwm_period[CARR_W-1:0]),
      .cmp (cmp_new[p])
    );
  end

  assign shadow_nxt = fired ? cmp_new : shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r[0]    <= start_index(PHASE_A_START_RST);
      idx_r[1]    <= start_index(PHASE_B_START_RST);
      idx_r[2]    <= start_index(PHASE_C_START_RST);
      shadow_r    <= '0;
    end else if (adv) begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      shadow_r <= shadow_nxt;
    end
  end

  a_fire_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fired) |=> (count_r == '0))
    else $error("sample timer not cleared after firing");

  a_restart_loads_a: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && restart) |=> (idx_r[0] == start_index($past(cfg.phase_a_start))))
    else $error("phase A index not reloaded on restart");

endmodule

@@ src/spwm_carrier.sv @@
`timescale 1ns / 1ps

module spwm_carrier import spwm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              restart,
  input  logic [CARR_W-1:0] top,
  input  cmp_vec_t          shadow,
  output logic [PHASES-1:0] level_nxt
);

  logic [CARR_W-1:0] count_r;
  logic [CARR_W-1:0] count_nxt;
  logic [CARR_W-1:0] c;
  cmp_vec_t          active_r;
  cmp_vec_t          active_nxt;
  logic [PHASES-1:0] level_r;

  // Restart forces the zero event on this tick
  assign c = restart ? '0 : count_r;

  // Latch compares at zero, set at zero, clear on match
  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      active_nxt[p] = (c == '0) ? shadow[p] : active_r[p];
      level_nxt[p]  = (c == '0) ? 1'b1 : level_r[p];
      if (c == active_nxt[p]) level_nxt[p] = 1'b0;
    end
  end

  assign count_nxt = (c >= top) ? '0 : c + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= '0;
      level_r  <= '0;
    end else if (adv) begin
      count_r  <= count_nxt;
      active_r <= active_nxt;
      level_r  <= level_nxt;
    end
  end

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && restart) |=> (count_r == (($past(top) == '0) ? '0 : CARR_W'(1))))
    else $error("carrier did not restart from zero");

endmodule

@@ src/three_phase_sine_pwm_generator.sv @@
// An input transfer's result is loaded into the output register on acceptance.
// Throughput: one item per cycle while the output register is free or drained;
// a tick updates sample timer, table lookup and compare scaling, and carrier step.
// Reset: synchronous active-low rst_n clears counters, compares and levels, loads
// the register defaults and the default phase indices; no clearing pass is needed.
`timescale 1ns / 1ps

module three_phase_sine_pwm_generator import spwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pwm_a,
  output logic                 out_pwm_b,
  output logic                 out_pwm_c,
  output logic                 out_sample_strobe
);

  cfg_t              cfg_r;
  logic              accept;
  logic              fired;
  cmp_vec_t          shadow_nxt;
  logic [PHASES-1:0] level_nxt;
  logic              out_valid_r;
  logic [PHASES-1:0] out_level_r;
  logic              out_strobe_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period    <= PWM_PERIOD_RST;
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.phase_a_start <= PHASE_A_START_RST;
      cfg_r.phase_b_start <= PHASE_B_START_RST;
      cfg_r.phase_c_start <= PHASE_C_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:    cfg_r.pwm_period    <= cfg_wdata[PERIOD_W-1:0];
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_wdata[SAMPLE_W-1:0];
        REG_PHASE_A_START: cfg_r.phase_a_start <= cfg_wdata[START_W-1:0];
        REG_PHASE_B_START: cfg_r.phase_b_start <= cfg_wdata[START_W-1:0];
        REG_PHASE_C_START: cfg_r.phase_c_start <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new tick whenever the output register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  spwm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (accept),
    .restart    (in_restart),
    .cfg        (cfg_r),
    .fired      (fired),
    .shadow_nxt (shadow_nxt)
  );

  spwm_carrier u_carrier (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (accept),
    .restart   (in_restart),
    .top       (cfg_r.pwm_period[CARR_W-1:0]),
    .shadow    (shadow_nxt),
    .level_nxt (level_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level_r  <= level_nxt;
      out_strobe_r <= fired;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_a         = out_level_r[0];
  assign out_pwm_b         = out_level_r[1];
  assign out_pwm_c         = out_level_r[2];
  assign out_sample_strobe = out_strobe_r;

  a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted tick left no result");

  a_strobe_blocks_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_restart) |=> !out_strobe_r)
    else $error("sample strobe on a restart tick");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import spwm_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          PRINT_LIMIT = 40;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI     = 64'd1686629713;

  typedef struct packed {
    logic pwm_a;
    logic pwm_b;
    logic pwm_c;
    logic strobe;
  } pwm_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_restart;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_pwm_a;
  logic                 out_pwm_b;
  logic                 out_pwm_c;
  logic                 out_sample_strobe;

  // Predicted block state and register copy
  logic [DUTY_W-1:0]   sine_lut [TABLE_DEPTH];
  cfg_t                model_cfg;
  logic [CARR_W-1:0]   carrier_cnt;
  logic [SAMPLE_W-1:0] sample_cnt;
  idx_vec_t            phase_idx;
  cmp_vec_t            pwm_shadow;
  cmp_vec_t            pwm_active;
  logic [PHASES-1:0]   pwm_level;

  pwm_result_t pending_ticks [$];
  pwm_result_t want;
  int          fail_count;
  int          result_num;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;

  three_phase_sine_pwm_generator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_a         (out_pwm_a),
    .out_pwm_b         (out_pwm_b),
    .out_pwm_c         (out_pwm_c),
    .out_sample_strobe (out_sample_strobe)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Sine point: quarter-wave Taylor series in Q30, folded by quadrant
  function automatic logic [DUTY_W-1:0] sine_point(input int unsigned i);
    logic [63:0] ph;
    logic [63:0] rem;
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] duty;
    logic [63:0] ent;
    logic [1:0]  quad;
    int          k;
    ph   = (64'(i) << 32) / TABLE_DEPTH;
    quad = ph[31:30];
    rem  = ph & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      rem = Q30_ONE - rem;
    end
    ang  = (rem * HALF_PI) >> 30;
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (k = 1; k <= 6; k++) begin
      term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > Q30_ONE) begin
      acc = Q30_ONE;
    end
    if (quad < 2'd2) begin
      duty = (Q30_ONE >> 1) + (acc >> 1);
    end else begin
      duty = (Q30_ONE >> 1) - (acc >> 1);
    end
    ent = (duty + (64'd1 << (29 - DUTY_W))) >> (30 - DUTY_W);
    if (ent > (64'd1 << DUTY_W) - 64'd1) begin
      ent = (64'd1 << DUTY_W) - 64'd1;
    end
    return DUTY_W'(ent);
  endfunction

  // Scale a table entry to a carrier compare value
  function automatic logic [CARR_W-1:0] duty_to_compare(input logic [IDX_W-1:0] idx);
    logic [63:0] prod;
    prod = 64'(sine_lut[idx]) * (64'(model_cfg.pwm_period) + 64'd1);
    return CARR_W'(prod >> DUTY_W);
  endfunction

  function automatic void load_start_indices();
    phase_idx[0] = IDX_W'(model_cfg.phase_a_start % TABLE_DEPTH);
    phase_idx[1] = IDX_W'(model_cfg.phase_b_start % TABLE_DEPTH);
    phase_idx[2] = IDX_W'(model_cfg.phase_c_start % TABLE_DEPTH);
  endfunction

  function automatic void reset_model();
    model_cfg = '{pwm_period: PWM_PERIOD_RST, sample_period: SAMPLE_PERIOD_RST,
                  phase_a_start: PHASE_A_START_RST, phase_b_start: PHASE_B_START_RST,
                  phase_c_start: PHASE_C_START_RST};
    carrier_cnt = '0;
    sample_cnt  = '0;
    pwm_shadow  = '0;
    pwm_active  = '0;
    pwm_level   = '0;
    load_start_indices();
  endfunction

  // Advance the predicted state by one tick and return the output levels
  function automatic pwm_result_t predict_tick(input logic restart);
    pwm_result_t       res;
    logic              fired;
    logic [CARR_W-1:0] c;
    int                p;
    fired = 1'b0;
    if (restart) begin
      load_start_indices();
      sample_cnt  = '0;
      carrier_cnt = '0;
    end else if (sample_cnt >= model_cfg.sample_period) begin
      fired      = 1'b1;
      sample_cnt = '0;
      for (p = 0; p < PHASES; p++) begin
        phase_idx[p]  = (phase_idx[p] < TABLE_DEPTH - 1) ? phase_idx[p] + 1'b1 : '0;
        pwm_shadow[p] = duty_to_compare(phase_idx[p]);
      end
    end else begin
      sample_cnt = sample_cnt + 1'b1;
    end
    // Latch at zero, clear on match; a match wins over zero
    c = carrier_cnt;
    for (p = 0; p < PHASES; p++) begin
      if (c == '0) begin
        pwm_active[p] = pwm_shadow[p];
        pwm_level[p]  = 1'b1;
      end
      if (c == pwm_active[p]) begin
        pwm_level[p] = 1'b0;
      end
    end
    carrier_cnt = (c >= model_cfg.pwm_period) ? '0 : c + 1'b1;
    res = '{pwm_a: pwm_level[0], pwm_b: pwm_level[1], pwm_c: pwm_level[2],
            strobe: fired};
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH result %0d: %s", $realtime, result_num, msg);
    end
    fail_count++;
  endtask

  // Check each output transfer, then record the prediction for each input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_ticks.size() == 0) begin
          report_mismatch("result with no tick outstanding");
        end else begin
          want = pending_ticks.pop_front();
          if (out_pwm_a !== want.pwm_a) begin
            report_mismatch($sformatf("pwm_a got %b expected %b", out_pwm_a, want.pwm_a));
          end
          if (out_pwm_b !== want.pwm_b) begin
            report_mismatch($sformatf("pwm_b got %b expected %b", out_pwm_b, want.pwm_b));
          end
          if (out_pwm_c !== want.pwm_c) begin
            report_mismatch($sformatf("pwm_c got %b expected %b", out_pwm_c, want.pwm_c));
          end
          if (out_sample_strobe !== want.strobe) begin
            report_mismatch($sformatf("sample_strobe got %b expected %b",
                                      out_sample_strobe, want.strobe));
          end
        end
        result_num++;
      end
      if (in_valid && in_ready) begin
        pending_ticks.push_back(predict_tick(in_restart));
      end
    end
  end

  // Receiver: random stalls, or a forced hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: abort when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one tick, idling at random first, and hold it until transfer
  task automatic send_tick(input logic restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PWM_PERIOD:    model_cfg.pwm_period    = val[PERIOD_W-1:0];
      REG_SAMPLE_PERIOD: model_cfg.sample_period = val[SAMPLE_W-1:0];
      REG_PHASE_A_START: model_cfg.phase_a_start = val[START_W-1:0];
      REG_PHASE_B_START: model_cfg.phase_b_start = val[START_W-1:0];
      REG_PHASE_C_START: model_cfg.phase_c_start = val[START_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_starts(input logic [START_W-1:0] a, input logic [START_W-1:0] b,
                            input logic [START_W-1:0] c);
    write_reg(REG_PHASE_A_START, {24'($urandom), a});
    write_reg(REG_PHASE_B_START, {24'($urandom), b});
    write_reg(REG_PHASE_C_START, {24'($urandom), c});
  endtask

  // Reset defaults give zero compares, so all outputs stay low
  task automatic test_reset_defaults();
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Largest periods and the extreme start indices
  task automatic test_register_extremes();
    wait_for_results();
    write_reg(REG_PWM_PERIOD, 32'h0000_FFFF);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    set_starts(8'd255, 8'd0, 8'd128);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  // Lower both tops below the running counts so both wrap at once
  task automatic test_counters_above_top();
    wait_for_results();
    write_reg(REG_PWM_PERIOD, 32'd2);
    write_reg(REG_SAMPLE_PERIOD, 32'd1);
    repeat (3) send_tick(1'b0);
  endtask

  // Full-scale entry gives compare equal to top; the trough gives compare zero
  task automatic test_compare_at_top();
    wait_for_results();
    write_reg(REG_PWM_PERIOD, 32'd3);
    write_reg(REG_SAMPLE_PERIOD, 32'd3);
    set_starts(8'd63, 8'd127, 8'd191);
    send_tick(1'b1);
    repeat (8) send_tick(1'b0);
  endtask

  // Carrier top of zero pins the counter, so every tick is a zero event
  task automatic test_zero_top();
    wait_for_results();
    write_reg(REG_PWM_PERIOD, 32'd0);
    repeat (3) send_tick(1'b0);
  endtask

  // Hold the receiver off long enough to back up the input
  task automatic test_backpressure();
    wait_for_results();
    write_reg(REG_PWM_PERIOD, 32'd5);
    write_reg(REG_SAMPLE_PERIOD, 32'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = 60;
    repeat (30) send_tick($urandom_range(99) < 5);
    wait_for_results();
  endtask

  task automatic apply_random_setting();
    logic [PERIOD_W-1:0] top;
    logic [SAMPLE_W-1:0] spd;
    case ($urandom_range(9))
      0:       top = 16'd1;
      1:       top = 16'hFFFF;
      2:       top = PERIOD_W'($urandom);
      default: top = PERIOD_W'($urandom_range(2, 24));
    endcase
    case ($urandom_range(9))
      0:       spd = '0;
      1:       spd = '1;
      2:       spd = $urandom;
      default: spd = $urandom_range(1, 12);
    endcase
    write_reg(REG_PWM_PERIOD, {16'($urandom), top});
    write_reg(REG_SAMPLE_PERIOD, spd);
    set_starts(START_W'($urandom), START_W'($urandom), START_W'($urandom));
  endtask

  // Random settings per phase, random ticks with occasional restarts
  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input int phases, input int per_phase);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (phases) begin
      wait_for_results();
      apply_random_setting();
      if ($urandom_range(9) < 6) begin
        send_tick(1'b1);
      end
      repeat (per_phase) send_tick($urandom_range(99) < 3);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    out_ready     = 1'b0;
    fail_count    = 0;
    result_num    = 0;
    stall_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sine_lut[i] = sine_point(i);
    end
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_counters_above_top();
    test_compare_at_top();
    test_zero_top();
    test_backpressure();
    test_random_traffic(20, 53, 4, 52);
    test_random_traffic(53, 20, 4, 52);
    test_random_traffic(0, 0, 4, 52);
    wait_for_results();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
